FILE: hdl/text_terminal_cell_writer_macros.svh
// Assertion helpers shared by the checker.
`ifndef TEXT_TERMINAL_CELL_WRITER_MACROS_SVH
`define TEXT_TERMINAL_CELL_WRITER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define TTCW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define TTCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also watches reset itself.
`define TTCW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ttcw_pkg.sv
`default_nettype none
package ttcw_pkg;

   // Default screen store size
   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 64;

   // Register port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Character codes
   localparam logic [15:0] BLANK_CODE      = 16'h0020;
   localparam logic [15:0] LINE_FEED       = 16'h000A;
   localparam logic [15:0] FIRST_PRINTABLE = 16'h0020;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_COLUMN_COUNT  = 3'd0,
      REG_ROW_COUNT     = 3'd1,
      REG_FG_RGBA       = 3'd2,
      REG_BG_RGBA       = 3'd3,
      REG_ATTRIBUTE     = 3'd4,
      REG_SCROLL_ENABLE = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  column_count;
      logic [6:0]  row_count;
      logic [31:0] fg_rgba;
      logic [31:0] bg_rgba;
      logic [7:0]  attribute;
      logic        scroll_enable;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      column_count:  8'd80,
      row_count:     7'd25,
      fg_rgba:       32'hFFFF_FFFF,
      bg_rgba:       32'h0000_0000,
      attribute:     8'h00,
      scroll_enable: 1'b1
   };

   typedef struct packed {
      logic [15:0] code;
      logic [31:0] fore;
      logic [31:0] back;
      logic [7:0]  attr;
   } cell_type;

   localparam cell_type RESET_BLANK = '{
      code: BLANK_CODE,
      fore: CFG_RESET.fg_rgba,
      back: CFG_RESET.bg_rgba,
      attr: CFG_RESET.attribute
   };

   // What the back end has to do for one beat
   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_PUT   = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_READ  = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         write;
      logic         scroll;
      logic         read_hit;
      logic [15:0]  code;
      logic [6:0]   cursor_x;
      logic [5:0]   cursor_y;
   } cmd_type;

   // Cell with the given code in the current colors
   function automatic cell_type make_cell(logic [15:0] code, cfg_type cfg);
      cell_type c;
      c.code = code;
      c.fore = cfg.fg_rgba;
      c.back = cfg.bg_rgba;
      c.attr = cfg.attribute;
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/ttcw_channels.sv
`default_nettype none
interface ttcw_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] char_code;
   logic [6:0]  read_col;
   logic [5:0]  read_row;

   modport source (output valid, operation, char_code, read_col, read_row, input ready);
   modport sink   (input valid, operation, char_code, read_col, read_row, output ready);
endinterface

interface ttcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  cursor_x;
   logic [5:0]  cursor_y;
   logic [15:0] cell_code;
   logic [31:0] cell_fore;
   logic [31:0] cell_back;
   logic [7:0]  cell_attr;
   logic        scrolled;

   modport source (output valid, cursor_x, cursor_y, cell_code, cell_fore, cell_back,
                   cell_attr, scrolled, input ready);
   modport sink   (input valid, cursor_x, cursor_y, cell_code, cell_fore, cell_back,
                   cell_attr, scrolled, output ready);
endinterface
`default_nettype wire

FILE: hdl/ttcw_front.sv
`default_nettype none
module ttcw_front #(
   parameter int MAX_COLS = ttcw_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = ttcw_pkg::DEF_MAX_ROWS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   ttcw_req_if.sink                              req_bus,
   input  logic                                  enable,
   input  logic                                  queue_full,
   input  logic [$clog2(MAX_COLS):0]             cols,
   input  logic [$clog2(MAX_ROWS):0]             rows,
   input  logic                                  scroll_enable,
   output logic                                  push,
   output ttcw_pkg::cmd_type                     cmd,
   output logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0] addr
);
   import ttcw_pkg::*;

   localparam int CW     = $clog2(MAX_COLS);
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int CNT_CW = CW + 1;
   localparam int CNT_RW = RW + 1;

   logic [CW-1:0]     cur_col_ff, cur_col_in;
   logic [RW-1:0]     cur_row_ff, cur_row_in;
   logic [CW-1:0]     col_c;
   logic [RW-1:0]     row_c;
   logic [CNT_CW-1:0] next_col;
   logic              last_row;
   logic              advance;

   // Take a beat whenever enabled and the queue has room
   assign req_bus.ready = enable && !queue_full;
   assign push          = req_bus.valid && req_bus.ready;

   // Classify the beat and move the cursor
   always_comb begin
      col_c    = (CNT_CW'(cur_col_ff) >= cols) ? CW'(cols - CNT_CW'(1)) : cur_col_ff;
      row_c    = (CNT_RW'(cur_row_ff) >= rows) ? RW'(rows - CNT_RW'(1)) : cur_row_ff;
      next_col = CNT_CW'(col_c) + CNT_CW'(1);
      last_row = (CNT_RW'(row_c) == rows - CNT_RW'(1));
      advance  = 1'b0;

      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      addr         = {row_c, col_c};
      cmd.kind     = CMD_NONE;
      cmd.write    = 1'b0;
      cmd.scroll   = 1'b0;
      cmd.read_hit = 1'b0;
      cmd.code     = req_bus.char_code;

      case (op_type'(req_bus.operation))
         OP_PUT: begin
            cmd.kind   = CMD_PUT;
            cur_col_in = col_c;
            cur_row_in = row_c;
            if (req_bus.char_code >= FIRST_PRINTABLE) begin
               cmd.write = 1'b1;
               if (next_col >= cols) begin
                  cur_col_in = '0;
                  advance    = 1'b1;
               end else begin
                  cur_col_in = CW'(next_col);
               end
            end else if (req_bus.char_code == LINE_FEED) begin
               cur_col_in = '0;
               advance    = 1'b1;
            end
            // Hold on the bottom row, scroll if allowed
            if (advance) begin
               if (last_row) begin
                  cmd.scroll = scroll_enable && (rows > CNT_RW'(1));
               end else begin
                  cur_row_in = row_c + RW'(1);
               end
            end
         end
         OP_CLEAR: begin
            cmd.kind = CMD_CLEAR;
         end
         OP_READ: begin
            cmd.kind     = CMD_READ;
            cmd.read_hit = (32'(req_bus.read_col) < MAX_COLS) &&
                           (32'(req_bus.read_row) < MAX_ROWS);
            addr         = {RW'(req_bus.read_row), CW'(req_bus.read_col)};
         end
         default: begin
            cmd.kind = CMD_NONE;
         end
      endcase

      cmd.cursor_x = 7'(cur_col_in);
      cmd.cursor_y = 6'(cur_row_in);
   end

   // Advance the cursor on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else if (push) begin
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/ttcw_queue.sv
`default_nettype none
module ttcw_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full     = (count_ff == NW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Step the pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the payloads
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/ttcw_back.sv
`default_nettype none
module ttcw_back #(
   parameter int MAX_COLS = ttcw_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = ttcw_pkg::DEF_MAX_ROWS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  cmd_valid,
   input  ttcw_pkg::cmd_type                     cmd,
   input  logic [$clog2(MAX_COLS)+$clog2(MAX_ROWS)-1:0] addr,
   output logic                                  pop,
   input  ttcw_pkg::cfg_type                     cfg,
   input  logic [$clog2(MAX_COLS):0]             cols,
   input  logic [$clog2(MAX_ROWS):0]             rows,
   output logic                                  init_busy,
   ttcw_rsp_if.source                            rsp_bus
);
   import ttcw_pkg::*;

   localparam int CW     = $clog2(MAX_COLS);
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int AW     = CW + RW;
   localparam int CNT_CW = CW + 1;
   localparam int CNT_RW = RW + 1;
   localparam int DEPTH  = 1 << AW;

   typedef enum logic [5:0] {
      ST_INIT  = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_CLEAR = 6'b000100,
      ST_COPY  = 6'b001000,
      ST_BLANK = 6'b010000,
      ST_READ  = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   cmd_type       cmd_ff, cmd_in;
   logic          wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;
   cell_type      rd_data_ff;
   cell_type      mem [DEPTH];

   logic          we;
   logic [AW-1:0] wa, ra;
   cell_type      wd;
   cell_type      fill;
   logic [RW-1:0] src_row;
   logic          last_col;
   logic          load_rsp;
   logic          rsp_read;
   logic          slot_free;
   cmd_type       src_cmd;

   logic          rsp_valid_ff;
   cmd_type       rsp_cmd_ff;
   cell_type      rsp_cell_ff;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign init_busy = (state_ff == ST_INIT);
   assign fill      = make_cell(BLANK_CODE, cfg);
   assign src_row   = row_ff + RW'(1);
   assign last_col  = (CNT_CW'(col_ff) == cols - CNT_CW'(1));
   assign src_cmd   = (state_ff == ST_IDLE) ? cmd : cmd_ff;

   // Sequence memory work for the command at the head of the queue
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      cmd_in     = cmd_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      pop        = 1'b0;
      load_rsp   = 1'b0;
      rsp_read   = 1'b0;
      ra         = addr;
      // Drain a pending copy write first
      we         = wr_pend_ff;
      wa         = wr_addr_ff;
      wd         = rd_data_ff;

      case (state_ff)
         ST_INIT: begin
            we     = 1'b1;
            wa     = idx_ff;
            wd     = RESET_BLANK;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid && slot_free) begin
               pop    = 1'b1;
               cmd_in = cmd;
               case (cmd.kind)
                  CMD_PUT: begin
                     if (cmd.write) begin
                        we = 1'b1;
                        wa = addr;
                        wd = make_cell(cmd.code, cfg);
                     end
                     if (cmd.scroll) begin
                        col_in   = '0;
                        row_in   = '0;
                        state_in = ST_COPY;
                     end else begin
                        load_rsp = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     idx_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_READ: begin
                     ra       = addr;
                     state_in = ST_READ;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            we     = 1'b1;
            wa     = idx_ff;
            wd     = fill;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == AW'(DEPTH - 1)) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            // Read the cell one row down, write it up next cycle
            ra         = {src_row, col_ff};
            wr_pend_in = 1'b1;
            wr_addr_in = {row_ff, col_ff};
            if (last_col) begin
               col_in = '0;
               if (CNT_RW'(row_ff) == rows - CNT_RW'(2)) begin
                  state_in = ST_BLANK;
               end else begin
                  row_in = src_row;
               end
            end else begin
               col_in = col_ff + CW'(1);
            end
         end
         ST_BLANK: begin
            if (!wr_pend_ff) begin
               we = 1'b1;
               wa = {RW'(rows - CNT_RW'(1)), col_ff};
               wd = fill;
               if (last_col) begin
                  load_rsp = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  col_in = col_ff + CW'(1);
               end
            end
         end
         ST_READ: begin
            load_rsp = 1'b1;
            rsp_read = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         idx_ff     <= '0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff     <= col_in;
      row_ff     <= row_in;
      cmd_ff     <= cmd_in;
      wr_addr_ff <= wr_addr_in;
   end

   // Cell store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[ra];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_cmd_ff  <= src_cmd;
         rsp_cell_ff <= (rsp_read && cmd_ff.read_hit) ? rd_data_ff : '0;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.cursor_x  = rsp_cmd_ff.cursor_x;
   assign rsp_bus.cursor_y  = rsp_cmd_ff.cursor_y;
   assign rsp_bus.scrolled  = rsp_cmd_ff.scroll;
   assign rsp_bus.cell_code = rsp_cell_ff.code;
   assign rsp_bus.cell_fore = rsp_cell_ff.fore;
   assign rsp_bus.cell_back = rsp_cell_ff.back;
   assign rsp_bus.cell_attr = rsp_cell_ff.attr;

endmodule
`default_nettype wire

FILE: hdl/text_terminal_cell_writer.sv
`default_nettype none
// Channel   Direction  Beat
// req_bus   in         operation, char_code, read_col, read_row
// rsp_bus   out        cursor_x, cursor_y, cell_code/fore/back/attr, scrolled
// csr_*     in         write enable, register index, write data (no handshake)
//
// Front end takes one beat per cycle into a two-entry command queue while it has room.
// Back end: plain put or other beat answered from IDLE, read via READ; a scrolling put
// copies rows up, then blanks the last row, one cell per cycle on the store's write port.
// Clear sweeps all 2^clog2(MAX_ROWS)*2^clog2(MAX_COLS) cells, one per cycle (8192 by default).
// After reset the same sweep fills the store with blanks; req_bus.ready is low meanwhile.
// Either side stalls on its own: a full queue drops ready, a held result stalls the back end.
module text_terminal_cell_writer #(
   parameter int MAX_COLS = ttcw_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = ttcw_pkg::DEF_MAX_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   ttcw_req_if.sink                          req_bus,
   ttcw_rsp_if.source                        rsp_bus,
   input  logic                              csr_write_enable,
   input  logic [ttcw_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ttcw_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import ttcw_pkg::*;

   localparam int CW     = $clog2(MAX_COLS);
   localparam int RW     = $clog2(MAX_ROWS);
   localparam int AW     = CW + RW;
   localparam int CNT_CW = CW + 1;
   localparam int CNT_RW = RW + 1;
   localparam int QW     = $bits(cmd_type) + AW;

   cfg_type           cfg_ff, cfg_in;
   logic [CNT_CW-1:0] cols;
   logic [CNT_RW-1:0] rows;
   logic              push, q_full, q_empty, pop, init_busy;
   cmd_type           f_cmd, b_cmd;
   logic [AW-1:0]     f_addr, b_addr;
   logic [QW-1:0]     q_out;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (reg_index_type'(csr_index))
            REG_COLUMN_COUNT:  cfg_in.column_count  = csr_write_data[7:0];
            REG_ROW_COUNT:     cfg_in.row_count     = csr_write_data[6:0];
            REG_FG_RGBA:       cfg_in.fg_rgba       = csr_write_data[31:0];
            REG_BG_RGBA:       cfg_in.bg_rgba       = csr_write_data[31:0];
            REG_ATTRIBUTE:     cfg_in.attribute     = csr_write_data[7:0];
            REG_SCROLL_ENABLE: cfg_in.scroll_enable = csr_write_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Clamp the area in use to the store
   always_comb begin
      if (cfg_ff.column_count == '0) begin
         cols = CNT_CW'(1);
      end else if (32'(cfg_ff.column_count) > MAX_COLS) begin
         cols = CNT_CW'(MAX_COLS);
      end else begin
         cols = CNT_CW'(cfg_ff.column_count);
      end
      if (cfg_ff.row_count == '0) begin
         rows = CNT_RW'(1);
      end else if (32'(cfg_ff.row_count) > MAX_ROWS) begin
         rows = CNT_RW'(MAX_ROWS);
      end else begin
         rows = CNT_RW'(cfg_ff.row_count);
      end
   end

   ttcw_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .enable        (!init_busy),
      .queue_full    (q_full),
      .cols          (cols),
      .rows          (rows),
      .scroll_enable (cfg_ff.scroll_enable),
      .push          (push),
      .cmd           (f_cmd),
      .addr          (f_addr)
   );

   ttcw_queue #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({f_addr, f_cmd}),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign b_cmd  = q_out[$bits(cmd_type)-1:0];
   assign b_addr = q_out[QW-1:$bits(cmd_type)];

   ttcw_back #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (b_cmd),
      .addr      (b_addr),
      .pop       (pop),
      .cfg       (cfg_ff),
      .cols      (cols),
      .rows      (rows),
      .init_busy (init_busy),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

FILE: hdl/ttcw_checker.sv
`default_nettype none
`include "text_terminal_cell_writer_macros.svh"
module ttcw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [6:0]  rsp_cursor_x,
   input wire logic [5:0]  rsp_cursor_y,
   input wire logic [15:0] rsp_cell_code,
   input wire logic [31:0] rsp_cell_fore,
   input wire logic [31:0] rsp_cell_back,
   input wire logic [7:0]  rsp_cell_attr,
   input wire logic        rsp_scrolled
);

   logic [101:0] rsp_payload;
   logic         rsp_stalled;
   logic         rsp_scroll;
   logic         rsp_cell_zero;

   // Collect the result beat for the checks below
   assign rsp_payload   = {rsp_cursor_x, rsp_cursor_y, rsp_cell_code, rsp_cell_fore,
                           rsp_cell_back, rsp_cell_attr, rsp_scrolled};
   assign rsp_stalled   = rsp_valid && !rsp_ready;
   assign rsp_scroll    = rsp_valid && rsp_scrolled;
   assign rsp_cell_zero = (rsp_cell_code == 16'd0) && (rsp_cell_fore == 32'd0) &&
                          (rsp_cell_back == 32'd0) && (rsp_cell_attr == 8'd0);

   // No result right out of reset
   `TTCW_ASSERT_NEXT_ALWAYS(a_reset_no_rsp, clock, reset, !rsp_valid, "result valid after reset")

   // Store fill runs after reset, so no beat is taken
   `TTCW_ASSERT_NEXT_ALWAYS(a_reset_no_ready, clock, reset, !req_ready, "ready during store fill")

   // Stalled result holds its payload
   `TTCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stalled, $stable(rsp_payload), "payload moved")

   // Only puts scroll, and a put returns no cell
   `TTCW_ASSERT_IMPL(a_scroll_no_cell, clock, reset, rsp_scroll, rsp_cell_zero, "cell on scroll")

endmodule

bind text_terminal_cell_writer ttcw_checker u_ttcw_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_cursor_x  (rsp_bus.cursor_x),
   .rsp_cursor_y  (rsp_bus.cursor_y),
   .rsp_cell_code (rsp_bus.cell_code),
   .rsp_cell_fore (rsp_bus.cell_fore),
   .rsp_cell_back (rsp_bus.cell_back),
   .rsp_cell_attr (rsp_bus.cell_attr),
   .rsp_scrolled  (rsp_bus.scrolled)
);
`default_nettype wire
